// ===== design/bec_pkg.sv =====
// Shared types, register indexes, the color palette and a divide-by-255 helper for the breathing envelope block.
`default_nettype none
package bec_pkg;

  localparam int unsigned DIV_W  = 32;   // divider dividend / quotient width
  localparam int unsigned DVS_W  = 18;   // divider divisor / remainder width
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_FADE_TIME      = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_HOLD_TIME      = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_OFF_TIME       = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MIN_LEVEL      = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MAX_LEVEL      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_ALT_CHANCE     = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_PALETTE_CHANCE = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_HALF_CHANCE    = 3'd7;

  localparam logic [3:0] PALETTE_LAST = 4'd13;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [6:0]  color_roll;
    logic [6:0]  bright_roll;
    logic        alt_pick;
    logic [3:0]  palette_pick;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_white;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_ramp;
    logic phase_ld;
    logic classify;
    logic mul1;
    logic mul2;
    logic level_ld;
    logic update;
    logic scale;
    logic out_ld;
  } bec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic need_div;
    logic out_free;
  } bec_sts_t;

  // {red, green, blue}; indexes past the table take the last entry
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = {8'd255, 8'd0,   8'd0};
      4'd1:    rgb = {8'd0,   8'd255, 8'd0};
      4'd2:    rgb = {8'd0,   8'd0,   8'd255};
      4'd3:    rgb = {8'd255, 8'd255, 8'd0};
      4'd4:    rgb = {8'd255, 8'd0,   8'd255};
      4'd5:    rgb = {8'd0,   8'd255, 8'd255};
      4'd6:    rgb = {8'd255, 8'd80,  8'd0};
      4'd7:    rgb = {8'd0,   8'd180, 8'd120};
      4'd8:    rgb = {8'd255, 8'd30,  8'd100};
      4'd9:    rgb = {8'd255, 8'd160, 8'd0};
      4'd10:   rgb = {8'd80,  8'd160, 8'd255};
      4'd11:   rgb = {8'd0,   8'd80,  8'd255};
      4'd12:   rgb = {8'd0,   8'd255, 8'd60};
      default: rgb = {8'd255, 8'd0,   8'd120};
    endcase
    return rgb;
  endfunction

  // floor(x / 255), exact for any x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== design/breathing_envelope_color_roller.sv =====
// Each request runs the shared 32-step divider once for the phase modulo and, on ramp ticks, once
//   more for the ramp quotient; flat and off ticks skip the second run. A new request is accepted
//   only after the previous result has been loaded into the output register.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, rst_n low): config registers take their defaults, color returns to
//   pink at full brightness with the roll flag set, and any pending result is dropped.
`default_nettype none
module breathing_envelope_color_roller (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire bec_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bec_pkg::out_item_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [bec_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [bec_pkg::CFG_DW-1:0]  cfg_wdata
);

  bec_pkg::bec_cmd_t cmd;
  bec_pkg::bec_sts_t sts;

  bec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bec_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== design/bec_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bec_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bec_pkg::DIV_W-1:0]  dividend,
  input  wire logic [bec_pkg::DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [bec_pkg::DIV_W-1:0]       quotient,
  output logic [bec_pkg::DVS_W-1:0]       remainder
);

  localparam int unsigned CNT_W = $clog2(bec_pkg::DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bec_pkg::DIV_W - 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [bec_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [bec_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [bec_pkg::DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [bec_pkg::DVS_W:0]    shifted;
  logic [bec_pkg::DVS_W:0]    diff;

  assign shifted = {rem_r, quo_r[bec_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[bec_pkg::DVS_W]) begin
        rem_nxt = diff[bec_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[bec_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[bec_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[bec_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== design/bec_dp.sv =====
// Datapath: config registers, phase and ramp math, color roller, output register.
`default_nettype none
module bec_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bec_pkg::bec_cmd_t           cmd,
  output bec_pkg::bec_sts_t                sts,
  input  wire bec_pkg::in_item_t           in_data,
  input  wire logic                        cfg_we,
  input  wire logic [bec_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [bec_pkg::CFG_DW-1:0]  cfg_wdata,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bec_pkg::out_item_t               out_data
);

  // config
  logic [15:0] fade_r, hold_r, off_r;
  logic [7:0]  min_r, max_r;
  logic [6:0]  alt_r, pal_r, hchance_r;

  // state
  logic        rolled_r;
  logic [7:0]  red_r, green_r, blue_r, white_r;
  logic        half_bright_r;
  logic        out_valid_r;

  // per-request working registers
  bec_pkg::in_item_t  req_r;
  logic [17:0]        phase_r;
  logic [14:0]        t_r;
  logic [22:0]        prod_r;
  logic [23:0]        num_r;
  logic [7:0]         level_r;
  logic [15:0]        p_red_r, p_green_r, p_blue_r, p_white_r;
  bec_pkg::out_item_t out_r;

  // divider hookup
  logic [bec_pkg::DIV_W-1:0] div_dividend, div_quo;
  logic [bec_pkg::DVS_W-1:0] div_divisor, div_rem;
  logic                      div_done;

  logic [14:0] half;
  logic [17:0] cycle_len, half_ext, hold_lim, down_lim, k;
  logic [14:0] k_clamp, t_down;
  logic        cls_need;
  logic [14:0] cls_t;
  logic [7:0]  cls_level;
  logic [7:0]  alt_plus_pal;
  logic [23:0] pal;
  logic [7:0]  q_red, q_green, q_blue, q_white;

  assign half      = fade_r[15:1];
  assign cycle_len = {2'b0, fade_r} + {2'b0, hold_r} + {2'b0, off_r};
  assign half_ext  = {3'b0, half};
  assign hold_lim  = half_ext + {2'b0, hold_r};
  assign down_lim  = {2'b0, fade_r} + {2'b0, hold_r};
  assign k         = phase_r - hold_lim;
  assign k_clamp   = (k > half_ext) ? half : k[14:0];
  assign t_down    = half - k_clamp;

  always_comb begin
    cls_need  = 1'b0;
    cls_t     = '0;
    cls_level = '0;
    if (phase_r < half_ext) begin
      cls_need = 1'b1;
      cls_t    = phase_r[14:0];
    end else if (phase_r < hold_lim) begin
      cls_level = max_r;
    end else if (phase_r < down_lim) begin
      if (half == '0) begin
        cls_level = min_r;
      end else begin
        cls_need = 1'b1;
        cls_t    = t_down;
      end
    end
  end

  assign div_dividend = cmd.div_ramp ? {8'd0, num_r} : req_r.now_ms;
  assign div_divisor  = cmd.div_ramp ? half_ext : cycle_len;

  bec_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign alt_plus_pal = {1'b0, alt_r} + {1'b0, pal_r};
  assign pal          = bec_pkg::palette_rgb(req_r.palette_pick);

  assign q_red   = bec_pkg::div255(p_red_r);
  assign q_green = bec_pkg::div255(p_green_r);
  assign q_blue  = bec_pkg::div255(p_blue_r);
  assign q_white = bec_pkg::div255(p_white_r);

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r        <= 16'd3000;
      hold_r        <= 16'd2000;
      off_r         <= 16'd5000;
      min_r         <= 8'd10;
      max_r         <= 8'd255;
      alt_r         <= 7'd10;
      pal_r         <= 7'd5;
      hchance_r     <= 7'd10;
      rolled_r      <= 1'b1;
      red_r         <= 8'd255;
      green_r       <= 8'd0;
      blue_r        <= 8'd170;
      white_r       <= 8'd0;
      half_bright_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bec_pkg::CFG_FADE_TIME:      fade_r    <= cfg_wdata;
          bec_pkg::CFG_HOLD_TIME:      hold_r    <= cfg_wdata;
          bec_pkg::CFG_OFF_TIME:       off_r     <= cfg_wdata;
          bec_pkg::CFG_MIN_LEVEL:      min_r     <= cfg_wdata[7:0];
          bec_pkg::CFG_MAX_LEVEL:      max_r     <= cfg_wdata[7:0];
          bec_pkg::CFG_ALT_CHANCE:     alt_r     <= cfg_wdata[6:0];
          bec_pkg::CFG_PALETTE_CHANCE: pal_r     <= cfg_wdata[6:0];
          bec_pkg::CFG_HALF_CHANCE:    hchance_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        if (level_r != 8'd0) begin
          rolled_r <= 1'b0;
        end else if (!rolled_r) begin
          rolled_r <= 1'b1;
          if ({1'b0, req_r.color_roll} < {1'b0, alt_r}) begin
            if (!req_r.alt_pick) begin
              red_r <= 8'd30; green_r <= 8'd0; blue_r <= 8'd180; white_r <= 8'd0;
            end else begin
              red_r <= 8'd0; green_r <= 8'd0; blue_r <= 8'd0; white_r <= 8'd255;
            end
          end else if ({1'b0, req_r.color_roll} < alt_plus_pal) begin
            red_r   <= pal[23:16];
            green_r <= pal[15:8];
            blue_r  <= pal[7:0];
            white_r <= 8'd0;
          end else begin
            red_r <= 8'd255; green_r <= 8'd0; blue_r <= 8'd170; white_r <= 8'd0;
          end
          half_bright_r <= (req_r.bright_roll < hchance_r);
        end
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.phase_ld) begin
      phase_r <= (cycle_len == '0) ? '0 : div_rem;
    end
    if (cmd.classify) begin
      t_r     <= cls_t;
      level_r <= cls_level;
    end
    if (cmd.mul1) begin
      prod_r <= {15'd0, min_r} * {8'd0, (half - t_r)};
    end
    if (cmd.mul2) begin
      num_r <= {1'b0, prod_r} + ({16'd0, max_r} * {9'd0, t_r});
    end
    if (cmd.level_ld) begin
      level_r <= div_quo[7:0];
    end
    if (cmd.scale) begin
      p_red_r   <= {8'd0, red_r} * {8'd0, level_r};
      p_green_r <= {8'd0, green_r} * {8'd0, level_r};
      p_blue_r  <= {8'd0, blue_r} * {8'd0, level_r};
      p_white_r <= {8'd0, white_r} * {8'd0, level_r};
    end
    if (cmd.out_ld) begin
      out_r.level     <= level_r;
      out_r.out_red   <= half_bright_r ? {1'b0, q_red[7:1]} : q_red;
      out_r.out_green <= half_bright_r ? {1'b0, q_green[7:1]} : q_green;
      out_r.out_blue  <= half_bright_r ? {1'b0, q_blue[7:1]} : q_blue;
      out_r.out_white <= half_bright_r ? {1'b0, q_white[7:1]} : q_white;
    end
  end

  assign sts.div_done = div_done;
  assign sts.need_div = cls_need;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== design/bec_ctrl.sv =====
// Controller: sequences one request through modulo, ramp math, roll and scaling.
`default_nettype none
module bec_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output bec_pkg::bec_cmd_t       cmd,
  input  wire bec_pkg::bec_sts_t  sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_GO,
    S_MOD_WAIT,
    S_CLASS,
    S_MUL1,
    S_MUL2,
    S_RAMP_GO,
    S_RAMP_WAIT,
    S_UPDATE,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (sts.div_done) begin
          cmd.phase_ld = 1'b1;
          state_nxt    = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = sts.need_div ? S_MUL1 : S_UPDATE;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_RAMP_GO;
      end
      S_RAMP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_ramp  = 1'b1;
        state_nxt     = S_RAMP_WAIT;
      end
      S_RAMP_WAIT: begin
        cmd.div_ramp = 1'b1;
        if (sts.div_done) begin
          cmd.level_ld = 1'b1;
          state_nxt    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for breathing_envelope_color_roller: envelope and color-roll checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 150;
  localparam int LONG_HOLD       = 400;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_PHASES      = 11;
  localparam int NUM_DIRECTED    = 17;

  typedef struct {
    logic [15:0] fade;
    logic [15:0] hold;
    logic [15:0] off;
    logic [7:0]  lo_level;
    logic [7:0]  hi_level;
    logic [6:0]  alt_pct;
    logic [6:0]  pal_pct;
    logic [6:0]  half_pct;
  } envelope_cfg_t;

  typedef struct {
    bec_pkg::in_item_t  tick;
    bit                 typed;
    bec_pkg::out_item_t want;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bec_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  bec_pkg::out_item_t out_data;
  logic cfg_we;
  logic [bec_pkg::CFG_AW-1:0] cfg_index;
  logic [bec_pkg::CFG_DW-1:0] cfg_wdata;

  breathing_envelope_color_roller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // shadow of the block's settings and latched color
  envelope_cfg_t cur_cfg;
  bit            color_settled;   // 1: color already rolled for this off stretch
  logic [7:0]    lamp_r, lamp_g, lamp_b, lamp_w;
  bit            lamp_dim;

  bec_pkg::out_item_t expected_pixels[$];
  int        ticks_sent;
  int        pixels_checked;
  int        mismatches;
  int        colors_rolled;
  int        settings_used;
  bit        sender_calm;

  envelope_cfg_t phase_cfgs[NUM_PHASES];
  tick_row_t     directed_ticks[NUM_DIRECTED];

  function automatic envelope_cfg_t mk_cfg(int fade, int hold, int off, int lo, int hi,
                                           int alt, int pal, int hb);
    envelope_cfg_t c;
    c.fade = 16'(fade); c.hold = 16'(hold); c.off = 16'(off);
    c.lo_level = 8'(lo); c.hi_level = 8'(hi);
    c.alt_pct = 7'(alt); c.pal_pct = 7'(pal); c.half_pct = 7'(hb);
    return c;
  endfunction

  function automatic logic [bec_pkg::CFG_DW-1:0] reg_value(envelope_cfg_t c,
                                                           logic [bec_pkg::CFG_AW-1:0] idx);
    case (idx)
      bec_pkg::CFG_FADE_TIME:      return c.fade;
      bec_pkg::CFG_HOLD_TIME:      return c.hold;
      bec_pkg::CFG_OFF_TIME:       return c.off;
      bec_pkg::CFG_MIN_LEVEL:      return bec_pkg::CFG_DW'(c.lo_level);
      bec_pkg::CFG_MAX_LEVEL:      return bec_pkg::CFG_DW'(c.hi_level);
      bec_pkg::CFG_ALT_CHANCE:     return bec_pkg::CFG_DW'(c.alt_pct);
      bec_pkg::CFG_PALETTE_CHANCE: return bec_pkg::CFG_DW'(c.pal_pct);
      default:                     return bec_pkg::CFG_DW'(c.half_pct);
    endcase
  endfunction

  function automatic logic [7:0] ramp_point(logic [31:0] half, logic [31:0] t);
    longint num;
    if (half == 0) return cur_cfg.lo_level;
    if (t > half) t = half;
    num = longint'(cur_cfg.lo_level) * longint'(half) +
          (longint'(cur_cfg.hi_level) - longint'(cur_cfg.lo_level)) * longint'(t);
    if (num < 0) num = 0;
    return 8'(num / longint'(half));
  endfunction

  function automatic logic [7:0] envelope_at(logic [31:0] now);
    logic [31:0] cycle, phase, half, d;
    cycle = 32'(cur_cfg.fade) + 32'(cur_cfg.hold) + 32'(cur_cfg.off);
    phase = (cycle == 0) ? 32'd0 : now % cycle;
    half  = 32'(cur_cfg.fade) >> 1;
    if (phase < half) return ramp_point(half, phase);
    if (phase < half + 32'(cur_cfg.hold)) return cur_cfg.hi_level;
    if (phase < 32'(cur_cfg.fade) + 32'(cur_cfg.hold)) begin
      d = phase - (half + 32'(cur_cfg.hold));
      return ramp_point(half, half - ((d > half) ? half : d));
    end
    return 8'd0;
  endfunction

  function automatic void latch_new_color(bec_pkg::in_item_t it);
    logic [23:0] rgb;
    logic [3:0]  p;
    if (int'(it.color_roll) < int'(cur_cfg.alt_pct)) begin
      if (it.alt_pick == 1'b0) begin
        lamp_r = 8'd30; lamp_g = 8'd0; lamp_b = 8'd180; lamp_w = 8'd0;
      end else begin
        lamp_r = 8'd0; lamp_g = 8'd0; lamp_b = 8'd0; lamp_w = 8'd255;
      end
    end else if (int'(it.color_roll) < int'(cur_cfg.alt_pct) + int'(cur_cfg.pal_pct)) begin
      p = (it.palette_pick > bec_pkg::PALETTE_LAST) ? bec_pkg::PALETTE_LAST
                                                      : it.palette_pick;
      case (p)
        4'd0:    rgb = {8'd255, 8'd0,   8'd0};
        4'd1:    rgb = {8'd0,   8'd255, 8'd0};
        4'd2:    rgb = {8'd0,   8'd0,   8'd255};
        4'd3:    rgb = {8'd255, 8'd255, 8'd0};
        4'd4:    rgb = {8'd255, 8'd0,   8'd255};
        4'd5:    rgb = {8'd0,   8'd255, 8'd255};
        4'd6:    rgb = {8'd255, 8'd80,  8'd0};
        4'd7:    rgb = {8'd0,   8'd180, 8'd120};
        4'd8:    rgb = {8'd255, 8'd30,  8'd100};
        4'd9:    rgb = {8'd255, 8'd160, 8'd0};
        4'd10:   rgb = {8'd80,  8'd160, 8'd255};
        4'd11:   rgb = {8'd0,   8'd80,  8'd255};
        4'd12:   rgb = {8'd0,   8'd255, 8'd60};
        default: rgb = {8'd255, 8'd0,   8'd120};
      endcase
      {lamp_r, lamp_g, lamp_b} = rgb;
      lamp_w = 8'd0;
    end else begin
      lamp_r = 8'd255; lamp_g = 8'd0; lamp_b = 8'd170; lamp_w = 8'd0;
    end
    lamp_dim = int'(it.bright_roll) < int'(cur_cfg.half_pct);
    color_settled = 1'b1;
    colors_rolled++;
  endfunction

  function automatic bec_pkg::out_item_t predict_pixel(bec_pkg::in_item_t it);
    bec_pkg::out_item_t px;
    logic [31:0] div;
    px.level = envelope_at(it.now_ms);
    if (px.level != 0) color_settled = 1'b0;
    else if (!color_settled) latch_new_color(it);
    div = lamp_dim ? 32'd510 : 32'd255;
    px.out_red   = 8'((32'(lamp_r) * 32'(px.level)) / div);
    px.out_green = 8'((32'(lamp_g) * 32'(px.level)) / div);
    px.out_blue  = 8'((32'(lamp_b) * 32'(px.level)) / div);
    px.out_white = 8'((32'(lamp_w) * 32'(px.level)) / div);
    return px;
  endfunction

  function automatic tick_row_t row(logic [31:0] now, int cr, int br, int ap, int pp,
                                    bit typed, bec_pkg::out_item_t want);
    tick_row_t r;
    r.tick = '{now_ms: now, color_roll: 7'(cr), bright_roll: 7'(br),
               alt_pick: 1'(ap), palette_pick: 4'(pp)};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic bec_pkg::out_item_t pix(int l, int r, int g, int b, int w);
    return '{level: 8'(l), out_red: 8'(r), out_green: 8'(g), out_blue: 8'(b),
             out_white: 8'(w)};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [6:0] pick_roll();
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 99));
  endfunction

  // aim most times at the envelope's corners, placed in a random period
  function automatic bec_pkg::in_item_t make_tick();
    bec_pkg::in_item_t it;
    logic [31:0] cycle, half, p, kmax;
    int sel;
    cycle = 32'(cur_cfg.fade) + 32'(cur_cfg.hold) + 32'(cur_cfg.off);
    half  = 32'(cur_cfg.fade) >> 1;
    sel   = $urandom_range(0, 99);
    it.color_roll   = pick_roll();
    it.bright_roll  = pick_roll();
    it.alt_pick     = 1'($urandom_range(0, 1));
    it.palette_pick = 4'($urandom_range(0, 15));
    if (sel < 15 || cycle == 0) begin
      it.now_ms = $urandom;
      return it;
    end
    if (sel < 30) begin
      p = $urandom_range(0, cycle - 1);
    end else begin
      case ($urandom_range(0, 4))
        0:       p = 32'd0;
        1:       p = half;
        2:       p = half + 32'(cur_cfg.hold);
        3:       p = 32'(cur_cfg.fade) + 32'(cur_cfg.hold);
        default: p = cycle;
      endcase
      p = p + $urandom_range(0, 4);
      p = (p >= 2) ? p - 2 : p;
    end
    kmax = (32'hFFFF_FFFF - p) / cycle;
    it.now_ms = $urandom_range(0, kmax) * cycle + p;
    return it;
  endfunction

  task automatic send_tick(bec_pkg::in_item_t it, bit typed, bec_pkg::out_item_t want);
    bec_pkg::out_item_t px;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    px = predict_pixel(it);
    expected_pixels.push_back(typed ? want : px);
    ticks_sent++;
  endtask

  task automatic run_ticks(int n);
    int gap;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 79) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_tick(make_tick(), 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(envelope_cfg_t c);
    logic [bec_pkg::CFG_AW-1:0] idx;
    for (int i = 0; i < 2 ** bec_pkg::CFG_AW; i++) begin
      idx = bec_pkg::CFG_AW'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= reg_value(c, idx);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  // result checker
  always @(posedge clk) begin
    bec_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: lvl=%0d r=%0d g=%0d b=%0d w=%0d", out_data.level,
                   out_data.out_red, out_data.out_green, out_data.out_blue, out_data.out_white);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.level !== want.level || out_data.out_red !== want.out_red ||
            out_data.out_green !== want.out_green || out_data.out_blue !== want.out_blue ||
            out_data.out_white !== want.out_white) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %0d: exp lvl=%0d rgbw=%0d,%0d,%0d,%0d got lvl=%0d rgbw=%0d,%0d,%0d,%0d",
                     pixels_checked, want.level, want.out_red, want.out_green, want.out_blue,
                     want.out_white, out_data.level, out_data.out_red, out_data.out_green,
                     out_data.out_blue, out_data.out_white);
        end
        pixels_checked++;
      end
    end
  end

  // receiver back-pressure, with one long hold-off partway through
  initial begin
    int len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && pixels_checked >= 500) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(20, 100)) @(posedge clk);
      end else begin
        len = pick_gap();
        if (len != 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // no request or result moving for too long means a hang
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: nothing moved for %0d cycles, %0d pixels pending",
                 idle_cycles, expected_pixels.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    ticks_sent = 0; pixels_checked = 0; mismatches = 0;
    colors_rolled = 0; settings_used = 1; sender_calm = 1'b0;

    cur_cfg = mk_cfg(3000, 2000, 5000, 10, 255, 10, 5, 10);
    color_settled = 1'b1;
    lamp_r = 8'd255; lamp_g = 8'd0; lamp_b = 8'd170; lamp_w = 8'd0;
    lamp_dim = 1'b0;

    // defaults: cycle 10000, half fade 1500, hold ends at 3500, off from 5000
    directed_ticks[0]  = row(0,            50,  50, 0, 0,  1, pix(10, 10, 0, 6, 0));
    directed_ticks[1]  = row(1500,         50,  50, 0, 0,  1, pix(255, 255, 0, 170, 0));
    directed_ticks[2]  = row(1499,         50,  50, 0, 0,  0, '0);
    directed_ticks[3]  = row(3499,         50,  50, 0, 0,  0, '0);
    directed_ticks[4]  = row(3500,         50,  50, 0, 0,  0, '0);
    directed_ticks[5]  = row(4999,         50,  50, 0, 0,  0, '0);
    // first off tick: white at half brightness
    directed_ticks[6]  = row(5000,          0,   0, 1, 0,  1, pix(0, 0, 0, 0, 0));
    directed_ticks[7]  = row(1500,         50,  50, 0, 0,  1, pix(255, 0, 0, 0, 127));
    // palette pick past the table falls back to the last entry
    directed_ticks[8]  = row(9999,         10,  99, 0, 15, 1, pix(0, 0, 0, 0, 0));
    // second off tick in a row: no new roll
    directed_ticks[9]  = row(32'hFFFF_FFFF, 127, 127, 1, 15, 1, pix(0, 0, 0, 0, 0));
    directed_ticks[10] = row(11500,        50,  50, 0, 0,  1, pix(255, 255, 0, 120, 0));
    // rolls above 100 land on pink
    directed_ticks[11] = row(15000,       127, 127, 0, 14, 1, pix(0, 0, 0, 0, 0));
    directed_ticks[12] = row(21500,        50,  50, 0, 0,  1, pix(255, 255, 0, 170, 0));
    directed_ticks[13] = row(6000,          9,   9, 0, 3,  1, pix(0, 0, 0, 0, 0));
    directed_ticks[14] = row(1500,         50,  50, 0, 0,  1, pix(255, 15, 0, 90, 0));
    directed_ticks[15] = row(16000,        14,  10, 1, 14, 1, pix(0, 0, 0, 0, 0));
    directed_ticks[16] = row(2000,         50,  50, 0, 0,  0, '0);

    phase_cfgs[0]  = mk_cfg(2, 0, 1, 1, 255, 0, 0, 0);
    phase_cfgs[1]  = mk_cfg(65535, 65535, 65535, 255, 1, 100, 0, 100);
    phase_cfgs[2]  = mk_cfg(1, 5, 3, 0, 200, 0, 100, 50);      // fade below two, zero min
    phase_cfgs[3]  = mk_cfg(0, 0, 0, 7, 9, 30, 30, 30);        // zero-length cycle
    phase_cfgs[4]  = mk_cfg(7, 3, 4, 0, 255, 127, 127, 127);   // chances past 100
    phase_cfgs[5]  = mk_cfg(20, 4, 6, 200, 0, 40, 50, 60);     // zero max, falling ramps
    phase_cfgs[6]  = mk_cfg(0, 6, 0, 255, 255, 0, 127, 0);
    for (int i = 7; i < NUM_PHASES - 1; i++)
      phase_cfgs[i] = mk_cfg($urandom_range(0, 40), $urandom_range(0, 20),
                             $urandom_range(0, 20), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 127),
                             $urandom_range(0, 127), $urandom_range(0, 127));
    phase_cfgs[NUM_PHASES - 1] = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                                        $urandom_range(0, 65535), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 127),
                                        $urandom_range(0, 127), $urandom_range(0, 127));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ticks[i]) begin
      send_tick(directed_ticks[i].tick, directed_ticks[i].typed, directed_ticks[i].want);
      if (i % 4 == 3) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    run_ticks(ITEMS_PER_PHASE - NUM_DIRECTED);

    foreach (phase_cfgs[i]) begin
      drain();
      apply_settings(phase_cfgs[i]);
      run_ticks(ITEMS_PER_PHASE);
    end

    drain();
    $display("covered %0d ticks over %0d register settings, %0d color rolls",
             ticks_sent, settings_used, colors_rolled);
    $display("%0d pixels checked, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
